FILE: design/dcc_command_packet_builder_defines.svh
// Assertion macros for the DCC command packet builder.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DCC_COMMAND_PACKET_BUILDER_DEFINES_SVH
`define DCC_COMMAND_PACKET_BUILDER_DEFINES_SVH
`ifndef SYNTHESIS
`define DCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dcc assertion failed");
`define DCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcc assertion failed");
`else
`define DCC_ASSERT(lbl, clk, rst, prop)
`define DCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/dcc_pkg.sv
// Shared types and constants of the DCC command packet builder.
// No dependencies.
`timescale 1ns / 1ps
package dcc_pkg;

   localparam logic [3:0] FUNC_T1ON   = 4'd0;
   localparam logic [3:0] FUNC_T1OFF  = 4'd1;
   localparam logic [3:0] FUNC_T2ON   = 4'd2;
   localparam logic [3:0] FUNC_T2OFF  = 4'd3;
   localparam logic [3:0] FUNC_ALLOFF = 4'd4;
   localparam logic [3:0] FUNC_ALLON  = 4'd5;
   localparam logic [3:0] FUNC_RESET  = 4'd6;
   localparam logic [3:0] FUNC_STATUS = 4'd7;
   localparam logic [3:0] FUNC_SEND2  = 4'd8;
   localparam logic [3:0] FUNC_SEND3  = 4'd9;
   localparam logic [3:0] FUNC_TXDONE = 4'd10;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_RESET_NOPWR = 2'd1;
   localparam logic [1:0] STATUS_NOT_POWERED = 2'd2;
   localparam logic [1:0] STATUS_CMD_ERROR   = 2'd3;

   localparam logic [1:0] TRACK_ONE = 2'd1;
   localparam logic [1:0] TRACK_TWO = 2'd2;

   localparam logic       CSR_ZERO_PERIOD = 1'b0;
   localparam logic       CSR_ONE_PERIOD  = 1'b1;

   localparam logic [15:0] ZERO_PERIOD_RESET = 16'd100;
   localparam logic [15:0] ONE_PERIOD_RESET  = 16'd58;

   localparam logic [7:0] FILL_BYTE = 8'hFF;
   localparam int         SYMBOLS   = 32;

   // bit 0 is track one, bit 1 is track two
   typedef struct packed {
      logic [1:0] power;
      logic [1:0] pending;
      logic [1:0] rst_mark;
   } flags_type;

   typedef struct packed {
      logic [1:0]  status;
      flags_type   flags;
      logic [31:0] packet;   // byte 0 in the top byte, sent first
      logic        emit;
   } job_type;

endpackage

FILE: design/dcc_front.sv
// Command front end: decodes each transfer, updates track flags and the work packet.
// Depends on dcc_pkg.
`timescale 1ns / 1ps
module dcc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  logic [3:0]       func,
   input  logic [1:0]       track,
   input  logic [7:0]       address,
   input  logic [7:0]       data_low,
   input  logic [7:0]       data_high,
   output logic             job_push,
   output dcc_pkg::job_type job
);
   import dcc_pkg::*;

   flags_type   flags_ff, flags_in;
   logic [31:0] packet_ff, packet_in;
   logic [1:0]  status;
   logic        emit;

   always_comb begin
      flags_in  = flags_ff;
      packet_in = packet_ff;
      status    = STATUS_OK;
      emit      = 1'b0;
      unique case (func)
         FUNC_T1ON:   flags_in.power[0] = 1'b1;
         FUNC_T1OFF:  flags_in.power[0] = 1'b0;
         FUNC_T2ON:   flags_in.power[1] = 1'b1;
         FUNC_T2OFF:  flags_in.power[1] = 1'b0;
         FUNC_ALLOFF: flags_in.power    = 2'b00;
         FUNC_ALLON:  flags_in.power    = 2'b11;
         FUNC_RESET: begin
            if (flags_ff.power == 2'b00) begin
               status = STATUS_RESET_NOPWR;
            end else begin
               // fill byte is kept from the previous packet
               packet_in        = {24'h000000, packet_ff[7:0]};
               flags_in.pending = 2'b11;
               flags_in.rst_mark = 2'b11;
               emit             = 1'b1;
            end
         end
         FUNC_STATUS: ;
         FUNC_SEND2, FUNC_SEND3: begin
            if (func == FUNC_SEND2) begin
               packet_in = {address, data_low, address ^ data_low, FILL_BYTE};
            end else begin
               packet_in = {address, data_low, data_high, address ^ data_low ^ data_high};
            end
            if (track == TRACK_ONE && flags_ff.power[0]) flags_in.pending[0] = 1'b1;
            if (track == TRACK_TWO && flags_ff.power[1]) flags_in.pending[1] = 1'b1;
            status = (flags_in.pending != 2'b00) ? STATUS_OK : STATUS_NOT_POWERED;
            emit   = 1'b1;
         end
         FUNC_TXDONE: begin
            if (track == TRACK_ONE || track == TRACK_TWO) begin
               flags_in.pending  = flags_ff.pending & ~track;
               flags_in.rst_mark = flags_ff.rst_mark & ~track;
            end
         end
         default: status = STATUS_CMD_ERROR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= '0;
         packet_ff <= '0;
      end else if (req_accept) begin
         flags_ff  <= flags_in;
         packet_ff <= packet_in;
      end
   end

   assign job_push    = req_accept;
   assign job.status  = status;
   assign job.flags   = flags_in;
   assign job.packet  = packet_in;
   assign job.emit    = emit;

endmodule

FILE: design/dcc_fifo.sv
// Two-entry job queue between the command front end and the symbol back end.
// Depends on dcc_pkg.
`timescale 1ns / 1ps
module dcc_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dcc_pkg::job_type push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output dcc_pkg::job_type pop_data
);
   import dcc_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

endmodule

FILE: design/dcc_back.sv
// Symbol back end: plays each job out as one status result or 32 bit-period symbols.
// Depends on dcc_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "dcc_command_packet_builder_defines.svh"
module dcc_back #(
   parameter int STORE_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  dcc_pkg::job_type   job,
   output logic               job_pop,
   input  logic [STORE_W-1:0] zero_period,
   input  logic [STORE_W-1:0] one_period,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);
   import dcc_pkg::*;

   localparam logic [4:0] LAST_SYM = 5'(SYMBOLS - 1);

   job_type      cur_ff;
   logic         cur_valid_ff;
   logic [4:0]   cnt_ff;
   logic         out_valid_ff;
   logic [23:0]  out_data_ff;
   logic         out_user_ff;
   logic         out_last_ff;

   logic         advance, finishing, load_job, sym_bit;
   logic [15:0]  period;
   logic [23:0]  data_in;

   assign finishing = !cur_ff.emit || (cnt_ff == LAST_SYM);
   assign advance   = cur_valid_ff && (!out_valid_ff || rsp_tready);
   assign load_job  = !cur_valid_ff || (advance && finishing);
   assign job_pop   = job_valid && load_job;
   // cnt counts up, bit 31 of the packet goes first
   assign sym_bit   = cur_ff.packet[~cnt_ff];

   always_comb begin
      period = '0;
      if (cur_ff.emit) period[STORE_W-1:0] = sym_bit ? one_period : zero_period;
      data_in = {period,
                 cur_ff.flags.rst_mark[1], cur_ff.flags.rst_mark[0],
                 cur_ff.flags.pending[1], cur_ff.flags.pending[0],
                 cur_ff.flags.power[1], cur_ff.flags.power[0], cur_ff.status};
   end

   always_ff @(posedge clock) begin
      if (job_pop) cur_ff <= job;
      if (advance) begin
         out_data_ff <= data_in;
         out_user_ff <= cur_ff.emit;
         out_last_ff <= finishing;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_job) cur_valid_ff <= job_valid;
         if (advance) cnt_ff <= finishing ? 5'd0 : cnt_ff + 5'd1;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   `DCC_ASSERT(a_cnt_only_emitting, clock, reset, (cnt_ff != 5'd0) |-> (cur_valid_ff && cur_ff.emit))
   `DCC_ASSERT(a_plain_is_last, clock, reset, (out_valid_ff && !out_user_ff) |-> out_last_ff)
   `DCC_ASSERT_NEXT(a_pop_loads, clock, reset, job_pop, cur_valid_ff && cnt_ff == 5'd0)

endmodule

FILE: design/dcc_command_packet_builder.sv
// Top level of the DCC command packet builder: configuration registers and wiring.
// Depends on dcc_pkg, dcc_front, dcc_fifo and dcc_back.
//
// Usage: commands arrive on the req_ stream, one per transfer. Each command
// updates the track flags at once and queues a job. Power, status, txdone,
// failed reset and invalid commands give one result with symbol_valid low;
// a good reset, send2 and send3 give 32 symbol results, MSB of byte 0 first,
// with rsp_tlast on the 32nd. Every result carries status and the flags
// after its command.
// Each job passes from the queue entry through the back end's job register to
// the result register. Throughput: one result per cycle while a job is queued
// and the receiver takes results, the back end playing one symbol a cycle.
// A two-entry queue lets the front take commands while symbols play out.
// When the receiver stalls, the result register holds and the queue fills;
// req_tready drops only when the queue is full.
// Reset clears all flags, the work packet and the queue, and loads the periods
// with 100 (zero bit) and 58 (one bit). csr_ writes take effect at once and the
// user must make them only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module dcc_command_packet_builder #(
   parameter int PERIOD_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[3:0], track[5:4], address[13:6], data_low[21:14], data_high[29:22]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], power_one[2], power_two[3], pending_one[4], pending_two[5],
   // reset_one[6], reset_two[7], symbol_period[23:8]
   output logic [23:0] rsp_tdata,
   // symbol_valid[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import dcc_pkg::*;

   localparam int STORE_W = (PERIOD_WIDTH < 16) ? PERIOD_WIDTH : 16;

   logic [STORE_W-1:0] zero_period_ff, one_period_ff;
   logic               req_accept, push, full, pop_valid, pop;
   job_type            push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_period_ff <= ZERO_PERIOD_RESET[STORE_W-1:0];
         one_period_ff  <= ONE_PERIOD_RESET[STORE_W-1:0];
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZERO_PERIOD: zero_period_ff <= csr_wdata[STORE_W-1:0];
            default:         one_period_ff  <= csr_wdata[STORE_W-1:0];
         endcase
      end
   end

   assign req_tready = !full;
   assign req_accept = req_tvalid && req_tready;

   dcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .func       (req_tdata[3:0]),
      .track      (req_tdata[5:4]),
      .address    (req_tdata[13:6]),
      .data_low   (req_tdata[21:14]),
      .data_high  (req_tdata[29:22]),
      .job_push   (push),
      .job        (push_job)
   );

   dcc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_job)
   );

   dcc_back #(
      .STORE_W (STORE_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (pop_valid),
      .job         (pop_job),
      .job_pop     (pop),
      .zero_period (zero_period_ff),
      .one_period  (one_period_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: verif/tb.sv
// Self-checking bench for dcc_command_packet_builder: directed command table, then
// random command bursts under several bit-period settings, with stalls on both streams.
// Depends on dcc_pkg and the design files; reads nothing at run time.
`timescale 1ns / 1ps
module tb;
   import dcc_pkg::*;

   localparam logic [3:0] FUNC_FIRST_INVALID = 4'd11;
   localparam int         HOLD_CYCLES        = 400;
   localparam int         IDLE_LIMIT         = 2000;
   localparam int         PHASES             = 6;
   localparam int         PHASE_ITEMS        = 80;

   typedef struct packed {
      logic [3:0] func;
      logic [1:0] track;
      logic [7:0] addr;
      logic [7:0] lo;
      logic [7:0] hi;
   } command_type;

   typedef struct packed {
      logic [1:0]  status;
      flags_type   flags;
      logic [15:0] period;
      logic        valid;
      logic        last;
   } symbol_type;

   typedef struct packed {
      command_type cmd;
      logic        typed;
      logic [1:0]  status;
      flags_type   flags;
   } row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_index  = CSR_ZERO_PERIOD;
   logic [15:0] csr_wdata  = '0;

   // shared between stimulus and receiver
   logic steady       = 1'b0;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;
   int   hold_count   = 0;
   int   stall_left   = 0;

   // predictor state
   logic [1:0]  track_power;
   logic [1:0]  track_pending;
   logic [1:0]  reset_marks;
   logic [31:0] work_packet;   // byte 0 in the top byte
   logic [15:0] zero_bit_period;
   logic [15:0] one_bit_period;
   symbol_type  forecast[$];
   symbol_type  awaited_symbols[$];
   row_type     command_table[$];

   int mismatches   = 0;
   int symbols_seen = 0;
   int items_sent   = 0;
   int packets_sent = 0;
   int idle_cycles  = 0;

   dcc_command_packet_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Updates the track flags and work packet, and fills forecast with the symbols due.
   function automatic void apply_command(input command_type c);
      logic [1:0] st;
      logic       compiled;
      symbol_type s;
      st = STATUS_OK;
      compiled = 1'b0;
      forecast.delete();
      case (c.func)
         FUNC_T1ON:   track_power[0] = 1'b1;
         FUNC_T1OFF:  track_power[0] = 1'b0;
         FUNC_T2ON:   track_power[1] = 1'b1;
         FUNC_T2OFF:  track_power[1] = 1'b0;
         FUNC_ALLOFF: track_power = 2'b00;
         FUNC_ALLON:  track_power = 2'b11;
         FUNC_RESET: begin
            if (track_power == 2'b00) begin
               st = STATUS_RESET_NOPWR;
            end else begin
               // fill byte stays as it was
               work_packet[31:8] = '0;
               track_pending = 2'b11;
               reset_marks = 2'b11;
               compiled = 1'b1;
            end
         end
         FUNC_STATUS: ;
         FUNC_SEND2, FUNC_SEND3: begin
            if (c.func == FUNC_SEND2)
               work_packet = {c.addr, c.lo, c.addr ^ c.lo, FILL_BYTE};
            else
               work_packet = {c.addr, c.lo, c.hi, c.addr ^ c.lo ^ c.hi};
            if (c.track == TRACK_ONE && track_power[0]) track_pending[0] = 1'b1;
            if (c.track == TRACK_TWO && track_power[1]) track_pending[1] = 1'b1;
            st = (track_pending != 2'b00) ? STATUS_OK : STATUS_NOT_POWERED;
            compiled = 1'b1;
         end
         FUNC_TXDONE: begin
            if (c.track == TRACK_ONE || c.track == TRACK_TWO) begin
               track_pending &= ~c.track;
               reset_marks &= ~c.track;
            end
         end
         default: st = STATUS_CMD_ERROR;
      endcase
      s.status = st;
      s.flags.power = track_power;
      s.flags.pending = track_pending;
      s.flags.rst_mark = reset_marks;
      if (compiled) begin
         for (int n = 0; n < SYMBOLS; n++) begin
            s.period = work_packet[31 - n] ? one_bit_period : zero_bit_period;
            s.valid = 1'b1;
            s.last = (n == SYMBOLS - 1);
            forecast.push_back(s);
         end
      end else begin
         s.period = '0;
         s.valid = 1'b0;
         s.last = 1'b1;
         forecast.push_back(s);
      end
   endfunction

   function automatic logic [7:0] data_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic command_type random_command();
      command_type c;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)       c.func = FUNC_T1ON;
      else if (roll < 13) c.func = FUNC_T1OFF;
      else if (roll < 21) c.func = FUNC_T2ON;
      else if (roll < 26) c.func = FUNC_T2OFF;
      else if (roll < 30) c.func = FUNC_ALLOFF;
      else if (roll < 36) c.func = FUNC_ALLON;
      else if (roll < 44) c.func = FUNC_RESET;
      else if (roll < 48) c.func = FUNC_STATUS;
      else if (roll < 66) c.func = FUNC_SEND2;
      else if (roll < 82) c.func = FUNC_SEND3;
      else if (roll < 94) c.func = FUNC_TXDONE;
      else                c.func = 4'($urandom_range(FUNC_FIRST_INVALID, 15));
      if ($urandom_range(0, 4) != 0)
         c.track = 2'($urandom_range(TRACK_ONE, TRACK_TWO));
      else
         c.track = $urandom_range(0, 1) ? 2'd3 : 2'd0;
      c.addr = data_byte();
      c.lo = data_byte();
      c.hi = data_byte();
      return c;
   endfunction

   task automatic add_row(input logic [3:0] func, input logic [1:0] track,
                          input logic [7:0] addr, input logic [7:0] lo, input logic [7:0] hi,
                          input logic typed, input logic [1:0] status, input flags_type flags);
      row_type r;
      r.cmd = '{func: func, track: track, addr: addr, lo: lo, hi: hi};
      r.typed = typed;
      r.status = status;
      r.flags = flags;
      command_table.push_back(r);
   endtask

   // Offers one command until the transfer, queues what it should produce, then may idle.
   task automatic run_command(input row_type r);
      symbol_type s;
      int gap, roll;
      req_tdata <= {2'b00, r.cmd.hi, r.cmd.lo, r.cmd.addr, r.cmd.track, r.cmd.func};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_command(r.cmd);
      items_sent++;
      if (forecast.size() > 1) packets_sent++;
      if (r.typed) begin
         s.status = r.status;
         s.flags = r.flags;
         s.period = '0;
         s.valid = 1'b0;
         s.last = 1'b1;
         awaited_symbols.push_back(s);
      end else begin
         foreach (forecast[i]) awaited_symbols.push_back(forecast[i]);
      end
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) gap = 0;
      else if (roll < 90)      gap = $urandom_range(1, 3);
      else                     gap = $urandom_range(8, 40);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin : receiver
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            rsp_tready <= 1'b1;
         end else if (roll < 95) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin : symbol_monitor
      symbol_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         symbols_seen++;
         if (awaited_symbols.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h user %b last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = awaited_symbols.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_tdata[1:0]));
            check_field("power", 16'(want.flags.power), 16'(rsp_tdata[3:2]));
            check_field("pending", 16'(want.flags.pending), 16'(rsp_tdata[5:4]));
            check_field("reset marks", 16'(want.flags.rst_mark), 16'(rsp_tdata[7:6]));
            check_field("symbol_period", want.period, rsp_tdata[23:8]);
            check_field("symbol_valid", 16'(want.valid), 16'(rsp_tuser));
            check_field("tlast", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [15:0] zero_p, one_p;
      row_type r;

      track_power = '0;
      track_pending = '0;
      reset_marks = '0;
      work_packet = '0;
      zero_bit_period = ZERO_PERIOD_RESET;
      one_bit_period = ONE_PERIOD_RESET;

      // func, track, addr, lo, hi, typed, status, {power, pending, marks}
      add_row(FUNC_STATUS, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b00_00_00);
      add_row(FUNC_RESET, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_RESET_NOPWR, 6'b00_00_00);
      add_row(FUNC_SEND2, TRACK_ONE, 8'hFF, 8'h00, 8'h00, 1'b0, STATUS_OK, '0);
      add_row(FUNC_FIRST_INVALID, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_CMD_ERROR,
              6'b00_00_00);
      add_row(4'd15, 2'd3, 8'hFF, 8'hFF, 8'hFF, 1'b1, STATUS_CMD_ERROR, 6'b00_00_00);
      add_row(FUNC_T1ON, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b01_00_00);
      add_row(FUNC_SEND2, TRACK_ONE, 8'h00, 8'hFF, 8'h00, 1'b0, STATUS_OK, '0);
      add_row(FUNC_T2ON, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b11_01_00);
      add_row(FUNC_SEND3, TRACK_TWO, 8'hFF, 8'hFF, 8'hFF, 1'b0, STATUS_OK, '0);
      // track 3 and track 0 sends store and emit without touching flags
      add_row(FUNC_SEND3, 2'd3, 8'hAA, 8'h55, 8'h0F, 1'b0, STATUS_OK, '0);
      add_row(FUNC_SEND2, 2'd0, 8'h80, 8'h01, 8'h00, 1'b0, STATUS_OK, '0);
      add_row(FUNC_RESET, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, STATUS_OK, '0);
      add_row(FUNC_TXDONE, TRACK_ONE, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b11_10_10);
      add_row(FUNC_TXDONE, 2'd3, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b11_10_10);
      add_row(FUNC_TXDONE, TRACK_TWO, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b11_00_00);
      add_row(FUNC_T1OFF, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b10_00_00);
      add_row(FUNC_T2OFF, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b00_00_00);
      add_row(FUNC_SEND3, TRACK_TWO, 8'h01, 8'h02, 8'h04, 1'b0, STATUS_OK, '0);
      add_row(FUNC_ALLON, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b11_00_00);
      add_row(FUNC_RESET, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, STATUS_OK, '0);
      add_row(FUNC_ALLOFF, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b00_11_11);
      // unpowered send still reports ok while a pending flag is left over
      add_row(FUNC_SEND2, TRACK_ONE, 8'h5A, 8'hA5, 8'h00, 1'b0, STATUS_OK, '0);
      add_row(FUNC_TXDONE, TRACK_ONE, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b00_10_10);
      add_row(4'd12, TRACK_ONE, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_CMD_ERROR, 6'b00_10_10);
      add_row(FUNC_TXDONE, TRACK_TWO, 8'h00, 8'h00, 8'h00, 1'b1, STATUS_OK, 6'b00_00_00);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (command_table[i]) run_command(command_table[i]);
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         while (awaited_symbols.size() != 0) @(posedge clock);
         repeat (6) @(posedge clock);
         case (phase)
            0: begin zero_p = 16'h0000; one_p = 16'hFFFF; end
            1: begin zero_p = 16'hFFFF; one_p = 16'h0000; end
            4: begin zero_p = 16'h8000; one_p = 16'h0001; end
            5: begin zero_p = ZERO_PERIOD_RESET; one_p = ONE_PERIOD_RESET; end
            default: begin
               zero_p = 16'($urandom_range(0, 65535));
               one_p = 16'($urandom_range(0, 65535));
            end
         endcase
         csr_we <= 1'b1;
         csr_index <= CSR_ZERO_PERIOD;
         csr_wdata <= zero_p;
         @(posedge clock);
         csr_index <= CSR_ONE_PERIOD;
         csr_wdata <= one_p;
         @(posedge clock);
         csr_we <= 1'b0;
         zero_bit_period = zero_p;
         one_bit_period = one_p;
         // phase 3 runs back to back and carries the long receiver hold-off
         steady <= (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 10) hold_request <= 1'b1;
            r.cmd = random_command();
            r.typed = 1'b0;
            r.status = STATUS_OK;
            r.flags = '0;
            run_command(r);
         end
         req_tvalid <= 1'b0;
      end

      while (awaited_symbols.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Covered %0d commands (%0d compiled packets), %0d results checked,",
               items_sent, packets_sent, symbols_seen);
      $display("over %0d bit-period settings plus the reset periods.", PHASES);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
